### src/aomd_pkg.sv
// Package with shared types, widths and register defaults for the onset marker detector.
package aomd_pkg;

  localparam int unsigned MaxMarkersDef = 64;
  localparam int unsigned MaxSamplesDef = 262144;

  localparam int unsigned SampleW = 16;
  localparam int unsigned CoefW   = 16;
  localparam int unsigned GainW   = 6;
  localparam int unsigned DistW   = 16;
  localparam int unsigned LevelW  = 17;
  localparam int unsigned PosW    = 18;
  localparam int unsigned CountW  = 7;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 32;

  localparam int unsigned MulAW = LevelW + 1;
  localparam int unsigned MulBW = CoefW + 1;
  localparam int unsigned ProdW = MulAW + MulBW;

  localparam logic [CfgIdxW-1:0] CfgEnvCoef  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMeanCoef = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgGain     = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgMinDist  = 2'd3;

  localparam logic [CoefW-1:0] EnvCoefRst  = 16'd655;
  localparam logic [CoefW-1:0] MeanCoefRst = 16'd98;
  localparam logic [GainW-1:0] GainRst     = 6'd6;
  localparam logic [DistW-1:0] MinDistRst  = 16'd1440;

  localparam logic [LevelW-1:0] LevelMax = 17'h10000;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_ENVM   = 7'b0000010,
    S_ENVU   = 7'b0000100,
    S_MEANM  = 7'b0001000,
    S_MEANU  = 7'b0010000,
    S_THRM   = 7'b0100000,
    S_DECIDE = 7'b1000000
  } state_e;

endpackage

### src/audio_onset_marker_detector_top.sv
// Onset marker detector: envelope follower, onset strength, running mean and marker decision.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------------
//  s_axis  | in        | tvalid / tready            | tdata: left, right; tuser: restart
//  m_axis  | out       | tvalid / tready            | tdata: position, count; tuser: onset
//  cfg     | in        | cfg_we_i (no wait)         | cfg_idx_i, cfg_data_i
//
// One sample pair passes the accept cycle and six sequencer steps, three of which share one
// 18x17 multiplier (envelope update, mean update, threshold). Once the loop is full a
// sample skips to the decision step. tready is high only while the sequencer idles; the
// result waits in an output register, and the final step holds while it is occupied.
// Reset loads the default register values and clears all loop state.
module audio_onset_marker_detector_top
  import aomd_pkg::*;
#(
  parameter int unsigned MAX_MARKERS = MaxMarkersDef,
  parameter int unsigned MAX_SAMPLES = MaxSamplesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // sample_left[15:0], sample_right[31:16]
  input  logic                s_axis_tuser,   // restart
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // onset_position[17:0], marker_count[24:18], 0
  output logic                m_axis_tuser,   // is_onset
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i
);

  localparam int unsigned IdxW  = $clog2(MAX_SAMPLES);
  localparam int unsigned CntW  = $clog2(MAX_MARKERS + 1);
  localparam int unsigned LastW = ((IdxW > DistW) ? IdxW : DistW) + 1;
  localparam int unsigned DiffW = LastW + 1;
  localparam logic [IdxW-1:0] IdxLast = IdxW'(MAX_SAMPLES - 1);
  localparam logic [CntW-1:0] CntMax  = CntW'(MAX_MARKERS);

  state_e state_q, state_d;

  logic [CoefW-1:0] env_coef_q, mean_coef_q;
  logic [GainW-1:0] gain_q;
  logic [DistW-1:0] min_dist_q;

  logic [LevelW-1:0] env_q, mean_q, absm_q, on_q;
  logic [IdxW-1:0]   idx_q;
  logic signed [LastW-1:0] last_q;
  logic [CntW-1:0]   markers_q;
  logic              full_q, skip_q;
  logic signed [ProdW-1:0] prod_q;

  logic                out_valid_q;
  logic                out_onset_q;
  logic [PosW-1:0]     out_pos_q;
  logic [CountW-1:0]   out_cnt_q;

  logic accept;
  logic proceed;
  logic signed [SampleW:0]  pair_sum;
  logic [LevelW-1:0]        pair_abs;
  logic signed [MulAW-1:0]  mul_a;
  logic signed [MulBW-1:0]  mul_b;
  logic signed [ProdW-1:0]  prod;
  logic signed [ProdW-1:0]  filt;
  logic signed [MulAW:0]    filt_next;
  logic [LevelW-1:0]        level_next;
  logic signed [MulAW-1:0]  rise;
  logic signed [DiffW-1:0]  gap;
  logic                     onset;
  logic [CntW-1:0]          markers_next;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign proceed       = !out_valid_q || m_axis_tready;

  assign pair_sum = $signed({s_axis_tdata[SampleW-1], s_axis_tdata[SampleW-1:0]})
                  + $signed({s_axis_tdata[2*SampleW-1], s_axis_tdata[2*SampleW-1:SampleW]});
  assign pair_abs = pair_sum[SampleW] ? LevelW'(-pair_sum) : LevelW'(pair_sum);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_ENVM: begin
        mul_a = $signed({1'b0, absm_q}) - $signed({1'b0, env_q});
        mul_b = $signed({1'b0, env_coef_q});
      end
      S_MEANM: begin
        mul_a = $signed({1'b0, on_q}) - $signed({1'b0, mean_q});
        mul_b = $signed({1'b0, mean_coef_q});
      end
      S_THRM: begin
        mul_a = $signed({1'b0, mean_q});
        mul_b = $signed({(MulBW - GainW)'(0), gain_q});
      end
      default: begin
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // round to nearest, ties up: (p + 2^15) >> 16 arithmetically
  assign filt = (prod_q + ProdW'(32768)) >>> 16;

  always_comb begin
    if (state_q == S_ENVU) begin
      filt_next = $signed({2'b0, env_q}) + $signed(filt[MulAW:0]);
    end else begin
      filt_next = $signed({2'b0, mean_q}) + $signed(filt[MulAW:0]);
    end
  end
  assign level_next = filt_next[LevelW-1:0];
  assign rise       = $signed({1'b0, level_next}) - $signed({1'b0, env_q});

  assign gap = $signed({(DiffW - IdxW)'(0), idx_q}) - DiffW'(last_q);
  assign onset = !skip_q && (idx_q >= IdxW'(2))
              && ($signed({(ProdW - LevelW)'(0), on_q}) > prod_q)
              && (gap >= $signed({(DiffW - DistW)'(0), min_dist_q}))
              && (markers_q < CntMax);
  assign markers_next = onset ? markers_q + CntW'(1) : markers_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (full_q && !s_axis_tuser) ? S_DECIDE : S_ENVM;
        end
      end
      S_ENVM:  state_d = S_ENVU;
      S_ENVU:  state_d = S_MEANM;
      S_MEANM: state_d = S_MEANU;
      S_MEANU: state_d = S_THRM;
      S_THRM:  state_d = S_DECIDE;
      S_DECIDE: begin
        if (proceed) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      env_coef_q  <= EnvCoefRst;
      mean_coef_q <= MeanCoefRst;
      gain_q      <= GainRst;
      min_dist_q  <= MinDistRst;
      env_q       <= '0;
      mean_q      <= '0;
      idx_q       <= '0;
      last_q      <= -$signed({(LastW - DistW)'(0), MinDistRst});
      markers_q   <= '0;
      full_q      <= 1'b0;
      skip_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgEnvCoef:  env_coef_q  <= cfg_data_i[CoefW-1:0];
          CfgMeanCoef: mean_coef_q <= cfg_data_i[CoefW-1:0];
          CfgGain:     gain_q      <= cfg_data_i[GainW-1:0];
          CfgMinDist:  min_dist_q  <= cfg_data_i[DistW-1:0];
          default: begin
          end
        endcase
      end
      if (state_q == S_DECIDE && proceed) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            skip_q <= full_q && !s_axis_tuser;
            if (s_axis_tuser) begin
              env_q     <= '0;
              mean_q    <= '0;
              idx_q     <= '0;
              last_q    <= -$signed({(LastW - DistW)'(0), min_dist_q});
              markers_q <= '0;
              full_q    <= 1'b0;
            end
          end
        end
        S_ENVU: begin
          env_q <= level_next;
        end
        S_MEANU: begin
          mean_q <= level_next;
        end
        S_DECIDE: begin
          if (proceed) begin
            if (!skip_q) begin
              markers_q <= markers_next;
              if (onset) begin
                last_q <= $signed({(LastW - IdxW)'(0), idx_q});
              end
              if (idx_q == IdxLast) begin
                full_q <= 1'b1;
              end else begin
                idx_q <= idx_q + IdxW'(1);
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q != S_DECIDE) begin
      prod_q <= prod;
    end
    if (accept) begin
      absm_q <= pair_abs;
    end
    if (state_q == S_ENVU) begin
      on_q <= rise[MulAW-1] ? '0 : rise[LevelW-1:0];
    end
    if (state_q == S_DECIDE && proceed) begin
      out_onset_q <= onset;
      out_pos_q   <= PosW'(idx_q);
      out_cnt_q   <= CountW'(markers_next);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_onset_q;
  assign m_axis_tdata  = {(OutDataW - PosW - CountW)'(0), out_cnt_q, out_pos_q};

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    markers_q <= CntMax)
    else $error("marker count beyond limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |-> (idx_q == IdxLast))
    else $error("loop full with sample index not at last position");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (env_q <= LevelMax) && (mean_q <= LevelMax))
    else $error("filter state out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> ($past(state_q) == S_DECIDE))
    else $error("result raised outside decision step");
`endif

endmodule

### bench/audio_onset_marker_detector_top_tb.sv
// Self-checking bench for the onset marker detector: directed rows, random audio loops, stalls.
`timescale 1ns / 100ps

module audio_onset_marker_detector_top_tb;
  import aomd_pkg::*;

  localparam int unsigned LoopLen     = 1024;
  localparam int unsigned MarkerLimit = MaxMarkersDef;
  localparam int          PhaseItems  = 90;
  localparam int          NumPhases   = 8;

  typedef struct packed {
    logic                      restart;
    logic signed [SampleW-1:0] left;
    logic signed [SampleW-1:0] right;
  } pair_t;

  typedef struct packed {
    logic              onset;
    logic [PosW-1:0]   pos;
    logic [CountW-1:0] count;
  } marker_t;

  typedef struct {
    pair_t   pair;
    bit      typed;
    marker_t result;
  } dir_row_t;

  dir_row_t dir_rows [20] = '{
    '{'{1'b0, 16'h0000, 16'h0000}, 1'b1, '{1'b0, 18'd0, 7'd0}},
    '{'{1'b0, 16'h7FFF, 16'h7FFF}, 1'b1, '{1'b0, 18'd1, 7'd0}},
    '{'{1'b0, 16'h8000, 16'h8000}, 1'b0, '0},
    '{'{1'b0, 16'h7FFF, 16'h8000}, 1'b0, '0},
    '{'{1'b0, 16'h8000, 16'h7FFF}, 1'b0, '0},
    '{'{1'b1, 16'hFFFF, 16'hFFFF}, 1'b1, '{1'b0, 18'd0, 7'd0}},
    '{'{1'b1, 16'h7FFF, 16'h7FFF}, 1'b1, '{1'b0, 18'd0, 7'd0}},
    '{'{1'b0, 16'h8000, 16'h8000}, 1'b1, '{1'b0, 18'd1, 7'd0}},
    '{'{1'b0, 16'h0000, 16'h0000}, 1'b0, '0},
    '{'{1'b0, 16'h0001, 16'h0000}, 1'b0, '0},
    '{'{1'b0, 16'hFFFF, 16'h0000}, 1'b0, '0},
    '{'{1'b0, 16'h4000, 16'h4000}, 1'b0, '0},
    '{'{1'b0, 16'h8000, 16'h8000}, 1'b0, '0},
    '{'{1'b0, 16'h0000, 16'h0000}, 1'b0, '0},
    '{'{1'b1, 16'h8000, 16'h8000}, 1'b1, '{1'b0, 18'd0, 7'd0}},
    '{'{1'b0, 16'h8000, 16'h8000}, 1'b1, '{1'b0, 18'd1, 7'd0}},
    '{'{1'b0, 16'h7FFF, 16'h7FFF}, 1'b0, '0},
    '{'{1'b0, 16'h5555, 16'hAAAA}, 1'b0, '0},
    '{'{1'b0, 16'hAAAA, 16'h5555}, 1'b0, '0},
    '{'{1'b0, 16'h0000, 16'h0000}, 1'b0, '0}
  };

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = CfgEnvCoef;
  logic [CfgW-1:0]     cfg_data_i    = '0;

  always #4 clk_i = ~clk_i;

  audio_onset_marker_detector_top #(
    .MAX_MARKERS(MarkerLimit),
    .MAX_SAMPLES(LoopLen)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  logic [CoefW-1:0]        env_coef_q;
  logic [CoefW-1:0]        mean_coef_q;
  logic [GainW-1:0]        gain_q;
  logic [DistW-1:0]        min_dist_q;
  logic [LevelW-1:0]       env_lvl;
  logic [LevelW-1:0]       mean_lvl;
  logic [PosW-1:0]         pos_cnt;
  logic signed [PosW:0]    last_mark;
  logic [CountW-1:0]       mark_cnt;
  bit                      loop_done;

  marker_t pending_markers [$];
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int sent_cnt       = 0;
  int checked_cnt    = 0;
  int onset_cnt      = 0;
  int fail_cnt       = 0;

  function automatic longint pole_step(longint diff, logic [CoefW-1:0] coef);
    return (diff * longint'(coef) + 32768) >>> 16;
  endfunction

  function automatic void clear_loop_state();
    env_lvl   = '0;
    mean_lvl  = '0;
    pos_cnt   = '0;
    last_mark = (PosW + 1)'(-longint'(min_dist_q));
    mark_cnt  = '0;
    loop_done = 1'b0;
  endfunction

  function automatic void reset_detector_model();
    env_coef_q  = EnvCoefRst;
    mean_coef_q = MeanCoefRst;
    gain_q      = GainRst;
    min_dist_q  = MinDistRst;
    clear_loop_state();
  endfunction

  function automatic marker_t detect_onset(pair_t pr);
    marker_t r;
    longint  mag;
    longint  prev;
    longint  rise;
    longint  idx;
    if (pr.restart) clear_loop_state();
    r.onset = 1'b0;
    if (loop_done) begin
      r.pos   = PosW'(LoopLen - 1);
      r.count = mark_cnt;
      return r;
    end
    mag = longint'($signed(pr.left)) + longint'($signed(pr.right));
    if (mag < 0) mag = -mag;
    prev    = longint'(env_lvl);
    env_lvl = LevelW'(prev + pole_step(mag - prev, env_coef_q));
    rise    = longint'(env_lvl) - prev;
    if (rise < 0) rise = 0;
    mean_lvl = LevelW'(longint'(mean_lvl) + pole_step(rise - longint'(mean_lvl), mean_coef_q));
    idx = longint'(pos_cnt);
    if (idx >= 2 && rise > longint'(mean_lvl) * longint'(gain_q)
        && idx - longint'(last_mark) >= longint'(min_dist_q) && mark_cnt < MarkerLimit) begin
      r.onset   = 1'b1;
      mark_cnt  = mark_cnt + 1'b1;
      last_mark = (PosW + 1)'(idx);
    end
    r.pos   = pos_cnt;
    r.count = mark_cnt;
    if (longint'(pos_cnt) + 1 >= LoopLen) loop_done = 1'b1;
    else pos_cnt = pos_cnt + 1'b1;
    return r;
  endfunction

  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk_i) begin
    marker_t got;
    marker_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got.onset = m_axis_tuser;
      got.pos   = m_axis_tdata[PosW-1:0];
      got.count = m_axis_tdata[PosW +: CountW];
      if (pending_markers.size() == 0) begin
        $error("unexpected result transaction: is_onset %0d position %0d count %0d",
               got.onset, got.pos, got.count);
        fail_cnt++;
      end else begin
        want = pending_markers.pop_front();
        checked_cnt++;
        if (want.onset) onset_cnt++;
        if (got.onset !== want.onset) begin
          $error("is_onset: expected %0d, got %0d", want.onset, got.onset);
          fail_cnt++;
        end
        if (got.pos !== want.pos) begin
          $error("onset_position: expected %0d, got %0d", want.pos, got.pos);
          fail_cnt++;
        end
        if (got.count !== want.count) begin
          $error("marker_count: expected %0d, got %0d", want.count, got.count);
          fail_cnt++;
        end
      end
    end
  end

  task automatic set_idle(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
      default: begin send_idle_pct = 12; recv_stall_pct = 12; end
    endcase
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CfgEnvCoef:  env_coef_q  = val[CoefW-1:0];
      CfgMeanCoef: mean_coef_q = val[CoefW-1:0];
      CfgGain:     gain_q      = val[GainW-1:0];
      CfgMinDist:  min_dist_q  = val[DistW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_settings(input logic [CoefW-1:0] env_c, input logic [CoefW-1:0] mean_c,
                                input logic [GainW-1:0] gain, input logic [DistW-1:0] min_gap);
    write_reg(CfgEnvCoef, env_c);
    write_reg(CfgMeanCoef, mean_c);
    write_reg(CfgGain, {10'($urandom), gain});
    write_reg(CfgMinDist, min_gap);
  endtask

  task automatic send_pair(input pair_t pr, input bit typed, input marker_t typed_result);
    marker_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pr.right, pr.left};
    s_axis_tuser  <= pr.restart;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = detect_onset(pr);
    pending_markers.push_back(typed ? typed_result : predicted);
    sent_cnt++;
    @(negedge clk_i);
  endtask

  // Loops of decaying hits with a restart on their first sample, mixed with raw noise.
  task automatic play_phase(input int n_items, input int min_run, input int max_run,
                            input int noise_pct);
    pair_t pr;
    int    amp;
    int    run_left;
    amp      = 0;
    run_left = $urandom_range(1) ? 0 : $urandom_range(min_run, max_run);
    repeat (n_items) begin
      if ($urandom_range(99) < noise_pct) begin
        pr.left    = 16'($urandom);
        pr.right   = 16'($urandom);
        pr.restart = ($urandom_range(7) == 0);
      end else begin
        pr.restart = (run_left == 0);
        if (run_left == 0) run_left = $urandom_range(min_run, max_run);
        run_left--;
        if ($urandom_range(15) == 0) amp = $urandom_range(1000, 32767);
        else amp = amp * 7 / 8;
        pr.left  = 16'(int'($urandom_range(2 * amp)) - amp);
        pr.right = 16'(int'($urandom_range(2 * amp)) - amp);
      end
      send_pair(pr, 1'b0, '0);
    end
  endtask

  task automatic drain();
    while (pending_markers.size() != 0) @(posedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  initial begin
    reset_detector_model();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    set_idle(0);
    foreach (dir_rows[i]) send_pair(dir_rows[i].pair, dir_rows[i].typed, dir_rows[i].result);
    for (int p = 0; p < NumPhases; p++) begin
      s_axis_tvalid <= 1'b0;
      drain();
      case (p)
        0: apply_settings(16'hFFFF, 16'hFFFF, 6'd1, 16'd0);
        1: apply_settings(16'd1, 16'd1, 6'd63, 16'hFFFF);
        2: apply_settings(16'd8000, 16'd0, 6'd0, 16'd2);
        3: apply_settings(16'd0, 16'd300, 6'd4, 16'd100);
        default: apply_settings(
            CoefW'($urandom_range(3) == 0 ? $urandom_range(65535) : $urandom_range(100, 8000)),
            CoefW'($urandom_range(3) == 0 ? $urandom_range(65535) : $urandom_range(0, 1500)),
            GainW'($urandom_range(63)),
            DistW'($urandom_range(3) == 0 ? $urandom_range(65535) : $urandom_range(0, 40)));
      endcase
      set_idle(p % 4);
      if (p == 2) play_phase(PhaseItems, 200, 400, 5);
      else play_phase(PhaseItems, 20, 150, 10);
    end
    s_axis_tvalid <= 1'b0;
    drain();
    $display("Sent %0d sample pairs over %0d register settings and four stall patterns.",
             sent_cnt, NumPhases + 1);
    $display("Compared %0d results, %0d of them onset markers.", checked_cnt, onset_cnt);
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
